FILE: hdl/ihdeq_pkg.sv
// Package for the interval heap double-ended queue.
// Holds sizes, data types, and the operation and status codes.
// No dependencies.
package ihdeq_pkg;

    localparam int Capacity  = 1024;
    localparam int DataWidth = 32;
    localparam int AddrWidth = $clog2(Capacity);
    localparam int CountWidth = $clog2(Capacity + 1);

    typedef logic [DataWidth-1:0]  t_data;
    typedef logic [AddrWidth-1:0]  t_addr;
    typedef logic [CountWidth-1:0] t_count;

    // operation codes
    localparam logic [1:0] ModePush   = 2'd0;
    localparam logic [1:0] ModePopMin = 2'd1;
    localparam logic [1:0] ModePopMax = 2'd2;
    localparam logic [1:0] ModeQuery  = 2'd3;

    // status codes
    localparam logic [1:0] StatusOk        = 2'd0;
    localparam logic [1:0] StatusPopEmpty  = 2'd1;
    localparam logic [1:0] StatusPushFull  = 2'd2;

endpackage

FILE: hdl/interval_heap_double_ended_queue_top.sv
// Interval heap double-ended priority queue, top level.
// Holds the element memory, the sift state machine and the result register.
// Depends on ihdeq_pkg.
//
// One request is handled at a time; o_stall stays high from acceptance until
// the result has been taken. All entries live in one memory with one read and
// one write port and a registered read, so each level's entries are read one
// per cycle and written back one per cycle. A query, a pop on an empty heap or a
// push on a full heap only reads the root ends for the result; a push climbs one
// level at a time and a pop descends one level at a time before that read. The
// result is held while i_stall is high.
module interval_heap_double_ended_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_removed_value,
    output logic [31:0] o_min_value,
    output logic [31:0] o_max_value,
    output logic [10:0] o_count,
    output logic        o_empty_res,
    output logic [1:0]  o_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH_RD, S_PUSH_WR, S_PUSH_FIX,
        S_LEVEL, S_PAIR, S_RD, S_EVAL, S_WR, S_FIN, S_OUT
    } t_state;

    // what the entries just read are used for
    typedef enum logic [1:0] {
        J_POP, J_PICK, J_PAIR, J_ROOT
    } t_job;

    // element memory, one read and one write port, registered read
    ihdeq_pkg::t_data mem [ihdeq_pkg::Capacity];
    ihdeq_pkg::t_addr rd_addr;
    ihdeq_pkg::t_data rd_data;
    logic             wr_en;
    ihdeq_pkg::t_addr wr_addr;
    ihdeq_pkg::t_data wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    t_state            r_state;
    t_job              r_job;
    ihdeq_pkg::t_count r_cnt;
    logic [1:0]        r_mode;
    ihdeq_pkg::t_data  r_val;
    ihdeq_pkg::t_data  r_removed;
    logic [1:0]        r_status;
    ihdeq_pkg::t_count r_node;     // node being sifted
    ihdeq_pkg::t_count r_p;        // parent node of the level
    ihdeq_pkg::t_count r_c;        // child node of the level
    ihdeq_pkg::t_addr  r_addr [4]; // entries read this level
    ihdeq_pkg::t_data  r_ent  [4];
    logic [2:0]        r_idx;      // read / write sequence index
    logic [2:0]        r_nrd;      // entries to read
    logic              r_single;   // child is a singleton
    logic              r_o_valid;
    ihdeq_pkg::t_data  r_o_min;
    ihdeq_pkg::t_data  r_o_max;

    // node helpers based on the live count
    function automatic logic node_live(input ihdeq_pkg::t_count n,
                                       input ihdeq_pkg::t_count c);
        logic [ihdeq_pkg::CountWidth:0] half;
        half = ({1'b0, c} + {{ihdeq_pkg::CountWidth{1'b0}}, 1'b1}) >> 1;
        return {1'b0, n} < half;
    endfunction
    function automatic logic is_single(input ihdeq_pkg::t_count n,
                                       input ihdeq_pkg::t_count c);
        return c[0] && (n == (c >> 1));
    endfunction
    function automatic ihdeq_pkg::t_addr lo_at(input ihdeq_pkg::t_count n,
                                               input ihdeq_pkg::t_count c);
        return is_single(n, c) ? ihdeq_pkg::t_addr'(c - ihdeq_pkg::t_count'(1))
                               : {n[ihdeq_pkg::AddrWidth-2:0], 1'b0};
    endfunction
    function automatic ihdeq_pkg::t_addr hi_at(input ihdeq_pkg::t_count n,
                                               input ihdeq_pkg::t_count c);
        return is_single(n, c) ? ihdeq_pkg::t_addr'(c - ihdeq_pkg::t_count'(1))
                               : {n[ihdeq_pkg::AddrWidth-2:0], 1'b1};
    endfunction

    // tree neighbors of the current node
    ihdeq_pkg::t_count left_c;
    ihdeq_pkg::t_count right_c;
    ihdeq_pkg::t_count parent_n;
    logic              sift_up;
    logic              low_side;
    logic              push_swap;
    assign left_c    = {r_node[ihdeq_pkg::CountWidth-2:0], 1'b1};
    assign right_c   = left_c + ihdeq_pkg::t_count'(1);
    assign parent_n  = (r_node - ihdeq_pkg::t_count'(1)) >> 1;
    assign sift_up   = (r_mode == ihdeq_pkg::ModePush);
    assign low_side  = (r_mode == ihdeq_pkg::ModePopMin);
    // odd count: the new value pairs with the last entry, smaller one goes low
    assign push_swap = r_cnt[0] && (r_val < rd_data);

    // four-entry sort, position order lo_p lo_c hi_c hi_p; singleton child: lo_p hi_p x
    ihdeq_pkg::t_data srt [4];
    logic             in_order;
    always_comb begin
        ihdeq_pkg::t_data lo_a, hi_a, lo_b, hi_b, mid_a, mid_b;
        lo_a  = (r_ent[1] < r_ent[0]) ? r_ent[1] : r_ent[0];
        hi_a  = (r_ent[1] < r_ent[0]) ? r_ent[0] : r_ent[1];
        lo_b  = (r_ent[3] < r_ent[2]) ? r_ent[3] : r_ent[2];
        hi_b  = (r_ent[3] < r_ent[2]) ? r_ent[2] : r_ent[3];
        mid_a = (lo_b < lo_a) ? lo_a : lo_b;
        mid_b = (hi_b < hi_a) ? hi_b : hi_a;
        srt[0] = (lo_b < lo_a) ? lo_b : lo_a;
        srt[3] = (hi_b < hi_a) ? hi_a : hi_b;
        srt[1] = (mid_b < mid_a) ? mid_b : mid_a;
        srt[2] = (mid_b < mid_a) ? mid_a : mid_b;
        in_order = (r_ent[0] < r_ent[1]) && (r_ent[1] < r_ent[2]) &&
                   (r_ent[2] < r_ent[3]);
        if (r_single) begin
            srt[3]   = r_ent[3];
            in_order = 1'b0;
            if (r_ent[2] < r_ent[0]) begin
                srt[0] = r_ent[2];
                srt[1] = r_ent[1];
                srt[2] = r_ent[0];
            end else if (r_ent[1] < r_ent[2]) begin
                srt[0] = r_ent[0];
                srt[1] = r_ent[2];
                srt[2] = r_ent[1];
            end else begin
                srt[0]   = r_ent[0];
                srt[1]   = r_ent[1];
                srt[2]   = r_ent[2];
                in_order = 1'b1;
            end
        end
    end

    // memory port control
    always_comb begin
        rd_addr = r_addr[r_idx[1:0]];
        wr_en   = 1'b0;
        wr_addr = r_addr[r_idx[1:0]];
        wr_data = srt[r_idx[1:0]];
        unique case (r_state)
            S_PUSH_WR: begin
                wr_en   = 1'b1;
                wr_addr = ihdeq_pkg::t_addr'(r_cnt);
                wr_data = push_swap ? rd_data : r_val;
            end
            S_PUSH_FIX: begin
                wr_en   = 1'b1;
                wr_addr = r_addr[0];
                wr_data = r_val;
            end
            S_EVAL: begin
                // pop: the last entry moves into the removed root end
                if (r_job == J_POP) begin
                    wr_en   = 1'b1;
                    wr_addr = r_addr[0];
                    wr_data = r_ent[1];
                end
            end
            S_WR: begin
                wr_en = 1'b1;
            end
            default: ;
        endcase
    end

    logic last_ok;
    assign last_ok = (r_cnt < ihdeq_pkg::t_count'(ihdeq_pkg::Capacity));
    assign o_stall = (r_state != S_IDLE);

    // control state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode    <= i_mode;
                        r_val     <= i_value;
                        r_removed <= '0;
                        r_status  <= ihdeq_pkg::StatusOk;
                        r_idx     <= '0;
                        unique case (i_mode)
                            ihdeq_pkg::ModePush: begin
                                if (!last_ok) begin
                                    r_status <= ihdeq_pkg::StatusPushFull;
                                    r_state  <= S_FIN;
                                end else begin
                                    // read the current last entry for the pairing step
                                    r_addr[0] <= ihdeq_pkg::t_addr'(r_cnt -
                                                 ihdeq_pkg::t_count'(1));
                                    r_state   <= S_PUSH_RD;
                                end
                            end
                            ihdeq_pkg::ModePopMin, ihdeq_pkg::ModePopMax: begin
                                if (r_cnt == '0) begin
                                    r_status <= ihdeq_pkg::StatusPopEmpty;
                                    r_state  <= S_FIN;
                                end else begin
                                    // read the root end, then the last entry
                                    r_addr[0] <= (i_mode == ihdeq_pkg::ModePopMin) ?
                                                 lo_at('0, r_cnt) : hi_at('0, r_cnt);
                                    r_addr[1] <= ihdeq_pkg::t_addr'(r_cnt -
                                                 ihdeq_pkg::t_count'(1));
                                    r_nrd     <= 3'd2;
                                    r_job     <= J_POP;
                                    r_state   <= S_RD;
                                end
                            end
                            ihdeq_pkg::ModeQuery: r_state <= S_FIN;
                        endcase
                    end
                end
                S_PUSH_RD: r_state <= S_PUSH_WR;
                S_PUSH_WR: begin
                    r_cnt   <= r_cnt + ihdeq_pkg::t_count'(1);
                    r_node  <= r_cnt >> 1;
                    r_state <= push_swap ? S_PUSH_FIX : S_LEVEL;
                end
                S_PUSH_FIX: r_state <= S_LEVEL;
                S_LEVEL: begin
                    if (sift_up) begin
                        if (r_node == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_p     <= parent_n;
                            r_c     <= r_node;
                            r_state <= S_PAIR;
                        end
                    end else if (!node_live(left_c, r_cnt)) begin
                        r_state <= S_FIN;
                    end else if (node_live(right_c, r_cnt)) begin
                        // compare the two children's ends on the sifting side
                        r_addr[0] <= low_side ? lo_at(left_c, r_cnt) : hi_at(left_c, r_cnt);
                        r_addr[1] <= low_side ? lo_at(right_c, r_cnt)
                                              : hi_at(right_c, r_cnt);
                        r_nrd   <= 3'd2;
                        r_idx   <= '0;
                        r_job   <= J_PICK;
                        r_state <= S_RD;
                    end else begin
                        r_p     <= r_node;
                        r_c     <= left_c;
                        r_state <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    // set up the parent and child ends of this level
                    r_single  <= is_single(r_c, r_cnt);
                    r_addr[0] <= lo_at(r_p, r_cnt);
                    if (is_single(r_c, r_cnt)) begin
                        r_addr[1] <= hi_at(r_p, r_cnt);
                        r_addr[2] <= lo_at(r_c, r_cnt);
                        r_nrd     <= 3'd3;
                    end else begin
                        r_addr[1] <= lo_at(r_c, r_cnt);
                        r_addr[2] <= hi_at(r_c, r_cnt);
                        r_nrd     <= 3'd4;
                    end
                    r_addr[3] <= hi_at(r_p, r_cnt);
                    r_idx     <= '0;
                    r_job     <= J_PAIR;
                    r_state   <= S_RD;
                end
                S_RD: begin
                    // one address per cycle, data lands in the cycle after
                    if (r_idx != 3'd0) begin
                        r_ent[r_idx[1:0] - 2'd1] <= rd_data;
                    end
                    if (r_idx == r_nrd) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                S_EVAL: begin
                    unique case (r_job)
                        J_POP: begin
                            r_removed <= r_ent[0];
                            r_cnt     <= r_cnt - ihdeq_pkg::t_count'(1);
                            r_node    <= '0;
                            r_state   <= S_LEVEL;
                        end
                        J_PICK: begin
                            r_p <= r_node;
                            if (low_side) begin
                                r_c <= (r_ent[0] < r_ent[1]) ? left_c : right_c;
                            end else begin
                                r_c <= (r_ent[0] < r_ent[1]) ? right_c : left_c;
                            end
                            r_state <= S_PAIR;
                        end
                        J_PAIR: begin
                            if (in_order) begin
                                r_state <= S_FIN;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_WR;
                            end
                        end
                        J_ROOT: begin
                            r_o_min   <= r_ent[0];
                            r_o_max   <= r_ent[1];
                            r_o_valid <= 1'b1;
                            r_state   <= S_OUT;
                        end
                    endcase
                end
                S_WR: begin
                    if (r_idx + 3'd1 == r_nrd) begin
                        r_node  <= sift_up ? r_p : r_c;
                        r_state <= S_LEVEL;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                S_FIN: begin
                    // read the root ends for the result
                    r_addr[0] <= lo_at('0, r_cnt);
                    r_addr[1] <= hi_at('0, r_cnt);
                    r_nrd     <= 3'd2;
                    r_idx     <= '0;
                    r_job     <= J_ROOT;
                    r_state   <= S_RD;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_o_valid <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_removed_value = r_removed;
    assign o_min_value     = (r_cnt == '0) ? '0 : r_o_min;
    assign o_max_value     = (r_cnt == '0) ? '0 : r_o_max;
    assign o_count         = r_cnt;
    assign o_empty_res     = (r_cnt == '0);
    assign o_status        = r_status;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ihdeq_pkg::t_count'(ihdeq_pkg::Capacity))
        else $error("count beyond capacity");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> $stable(r_cnt))
        else $error("count moved during output");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_min_value) &&
                                  $stable(o_max_value) && $stable(o_removed_value)))
        else $error("result changed while stalled");

endmodule

FILE: sim/tb_interval_heap_double_ended_queue_top.sv
// Testbench for the interval heap double-ended queue top level.
// Drives push/pop/query requests, predicts results with a behavioral heap, checks each field.
// Depends on ihdeq_pkg and interval_heap_double_ended_queue_top.
module tb_interval_heap_double_ended_queue_top;

    // result record
    typedef struct packed {
        logic [31:0] removed;
        logic [31:0] min_v;
        logic [31:0] max_v;
        logic [10:0] cnt;
        logic        empty;
        logic [1:0]  status;
    } t_heap_result;

    // directed row: request plus optional typed-in result
    typedef struct {
        logic [1:0]   mode;
        logic [31:0]  value;
        bit           fixed;
        t_heap_result res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_removed_value;
    logic [31:0] o_min_value;
    logic [31:0] o_max_value;
    logic [10:0] o_count;
    logic        o_empty_res;
    logic [1:0]  o_status;

    interval_heap_double_ended_queue_top DUT (.*);

    // predictor state
    logic [31:0]  heap_store [ihdeq_pkg::Capacity];
    int           heap_count;
    t_heap_result pending_results [$];
    int           mismatch_count;
    bit           input_done;
    bit           hold_off;
    bit           no_idle;
    longint       cycle_count;
    t_row         rows [$];

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic bit bool_single(int i);
        return (heap_count % 2 == 1) && i == (heap_count - 1) / 2;
    endfunction

    function automatic int lo_idx(int i);
        return bool_single(i) ? heap_count - 1 : 2 * i;
    endfunction

    function automatic int hi_idx(int i);
        return bool_single(i) ? heap_count - 1 : 2 * i + 1;
    endfunction

    function automatic bit node_alive(int i);
        return i < (heap_count + 1) / 2;
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [31:0] t;
        t = heap_store[a];
        heap_store[a] = heap_store[b];
        heap_store[b] = t;
    endfunction

    // order parent and child ends; 0 when already ordered
    function automatic bit order_nodes(int p, int c);
        int s [4];
        int a, b, x;
        if (bool_single(c)) begin
            a = lo_idx(p); b = hi_idx(p); x = lo_idx(c);
            if (heap_store[x] < heap_store[a]) swap_entries(x, a);
            else if (heap_store[b] < heap_store[x]) swap_entries(b, x);
            else return 1'b0;
            return 1'b1;
        end
        s[0] = lo_idx(p); s[1] = lo_idx(c); s[2] = hi_idx(c); s[3] = hi_idx(p);
        if (heap_store[s[0]] < heap_store[s[1]] && heap_store[s[1]] < heap_store[s[2]] &&
            heap_store[s[2]] < heap_store[s[3]]) return 1'b0;
        for (int i = 0; i < 4; i++)
            for (int j = i + 1; j < 4; j++)
                if (!(heap_store[s[i]] < heap_store[s[j]])) swap_entries(s[i], s[j]);
        return 1'b1;
    endfunction

    function automatic t_heap_result predict_heap_op(logic [1:0] mode, logic [31:0] value);
        t_heap_result r;
        logic [31:0] v, t;
        int i, l, rt, nxt, at;
        bit low_side;
        v = value;
        r = '0;
        if (mode == ihdeq_pkg::ModePush) begin
            if (heap_count >= ihdeq_pkg::Capacity) begin
                r.status = ihdeq_pkg::StatusPushFull;
            end else begin
                if (heap_count % 2 == 1 && v < heap_store[heap_count - 1]) begin
                    t = heap_store[heap_count - 1];
                    heap_store[heap_count - 1] = v;
                    v = t;
                end
                heap_store[heap_count] = v;
                heap_count++;
                i = (heap_count - 1) / 2;
                while (i > 0) begin
                    if (!order_nodes((i - 1) / 2, i)) break;
                    i = (i - 1) / 2;
                end
            end
        end else if (mode == ihdeq_pkg::ModePopMin || mode == ihdeq_pkg::ModePopMax) begin
            if (heap_count == 0) begin
                r.status = ihdeq_pkg::StatusPopEmpty;
            end else begin
                low_side = (mode == ihdeq_pkg::ModePopMin);
                at = low_side ? lo_idx(0) : hi_idx(0);
                swap_entries(at, heap_count - 1);
                r.removed = heap_store[heap_count - 1];
                heap_count--;
                i = 0;
                forever begin
                    l = 2 * i + 1; rt = 2 * i + 2;
                    if (!node_alive(l)) break;
                    if (node_alive(rt)) begin
                        if (low_side)
                            nxt = (heap_store[lo_idx(l)] < heap_store[lo_idx(rt)]) ? l : rt;
                        else
                            nxt = (heap_store[hi_idx(l)] < heap_store[hi_idx(rt)]) ? rt : l;
                    end else begin
                        nxt = l;
                    end
                    if (!order_nodes(i, nxt)) break;
                    i = nxt;
                end
            end
        end
        r.min_v = heap_count ? heap_store[lo_idx(0)] : '0;
        r.max_v = heap_count ? heap_store[hi_idx(0)] : '0;
        r.cnt = heap_count[10:0];
        r.empty = (heap_count == 0);
        return r;
    endfunction

    function automatic t_heap_result mk_res(logic [31:0] rm, logic [31:0] mn, logic [31:0] mx,
                                            int cnt, logic [1:0] st);
        t_heap_result r;
        r.removed = rm; r.min_v = mn; r.max_v = mx; r.cnt = cnt[10:0];
        r.empty = (cnt == 0); r.status = st;
        return r;
    endfunction

    function automatic void add_row(logic [1:0] m, logic [31:0] v, bit fx, t_heap_result r);
        t_row w;
        w.mode = m; w.value = v; w.fixed = fx; w.res = r;
        rows = {rows, w};
    endfunction

    // present one request and wait for its acceptance
    task automatic send_request(logic [1:0] mode, logic [31:0] value, bit fx, t_heap_result fr);
        t_heap_result pr;
        while (!no_idle && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pr = predict_heap_op(mode, value);
        if (fx && pr !== fr) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("directed row disagrees with predictor: row %h pred %h", fr, pr);
        end
        pending_results = {pending_results, pr};
    endtask

    // random value, biased toward extremes and repeats
    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        t_heap_result none;
        int target, p;
        logic [1:0] m;
        none = '0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_mode = ihdeq_pkg::ModeQuery; i_value = '0;
        i_stall = 1'b0;
        heap_count = 0; mismatch_count = 0; input_done = 0; hold_off = 0; no_idle = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_row(ihdeq_pkg::ModeQuery,  32'h0, 1, mk_res(0, 0, 0, 0, ihdeq_pkg::StatusOk));
        add_row(ihdeq_pkg::ModePopMin, 32'h0, 1, mk_res(0, 0, 0, 0, ihdeq_pkg::StatusPopEmpty));
        add_row(ihdeq_pkg::ModePopMax, 32'h0, 1, mk_res(0, 0, 0, 0, ihdeq_pkg::StatusPopEmpty));
        add_row(ihdeq_pkg::ModePush, 32'hFFFF_FFFF, 1,
                mk_res(0, '1, '1, 1, ihdeq_pkg::StatusOk));
        add_row(ihdeq_pkg::ModePush, 32'h0, 1, mk_res(0, 0, '1, 2, ihdeq_pkg::StatusOk));
        add_row(ihdeq_pkg::ModePopMax, 32'h0, 1, mk_res('1, 0, 0, 1, ihdeq_pkg::StatusOk));
        add_row(ihdeq_pkg::ModePopMin, 32'h0, 1, mk_res(0, 0, 0, 0, ihdeq_pkg::StatusOk));
        add_row(ihdeq_pkg::ModePush, 32'h5, 0, none);
        add_row(ihdeq_pkg::ModePush, 32'h5, 0, none);
        add_row(ihdeq_pkg::ModePush, 32'h5, 0, none);
        add_row(ihdeq_pkg::ModePush, 32'h5, 0, none);
        add_row(ihdeq_pkg::ModePush, 32'h3, 0, none);
        add_row(ihdeq_pkg::ModePush, 32'h8000_0000, 0, none);
        add_row(ihdeq_pkg::ModePush, 32'h7FFF_FFFF, 0, none);
        add_row(ihdeq_pkg::ModeQuery, 32'hFFFF_FFFF, 0, none);
        add_row(ihdeq_pkg::ModePopMin, 32'h0, 0, none);
        add_row(ihdeq_pkg::ModePopMax, 32'h0, 0, none);
        add_row(ihdeq_pkg::ModePopMin, 32'h0, 0, none);
        add_row(ihdeq_pkg::ModePopMax, 32'h0, 0, none);
        add_row(ihdeq_pkg::ModePopMin, 32'h0, 0, none);
        add_row(ihdeq_pkg::ModePopMax, 32'h0, 0, none);
        add_row(ihdeq_pkg::ModePopMin, 32'h0, 0, none);
        add_row(ihdeq_pkg::ModePopMin, 32'h0, 1, mk_res(0, 0, 0, 0, ihdeq_pkg::StatusPopEmpty));
        foreach (rows[k]) send_request(rows[k].mode, rows[k].value, rows[k].fixed, rows[k].res);

        // fill to capacity, then overflow pushes, then drain 300 entries
        for (int k = 0; k < ihdeq_pkg::Capacity; k++) begin
            if (k == 100) hold_off = 1;
            send_request(ihdeq_pkg::ModePush, rand_value(), 0, none);
        end
        send_request(ihdeq_pkg::ModePush, 32'hFFFF_FFFF, 0, none);
        send_request(ihdeq_pkg::ModePush, 32'h0, 0, none);
        send_request(ihdeq_pkg::ModeQuery, 32'h0, 0, none);
        for (int k = 0; k < 300; k++)
            send_request($urandom_range(1) ? ihdeq_pkg::ModePopMin : ihdeq_pkg::ModePopMax,
                         $urandom, 0, none);

        // random phases with shifting push bias
        no_idle = 1;
        for (int k = 0; k < 600; k++) begin
            if (k == 150) no_idle = 0;
            target = (k / 100) % 3;
            p = $urandom_range(99);
            if (p < (target == 0 ? 70 : target == 1 ? 45 : 25)) m = ihdeq_pkg::ModePush;
            else if (p < 92)
                m = $urandom_range(1) ? ihdeq_pkg::ModePopMin : ihdeq_pkg::ModePopMax;
            else m = ihdeq_pkg::ModeQuery;
            send_request(m, rand_value(), 0, none);
        end
        i_valid <= 1'b0;
        input_done = 1;
    end

    // receiver stall: random idling, one long hold-off
    initial begin
        int hold_cycles;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                hold_off = 0;
                i_stall <= 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 400) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
            end
            i_stall <= (!no_idle && $urandom_range(99) < 15);
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_heap_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_removed_value, o_min_value, o_max_value, o_count, o_empty_res, o_status};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: removed %h/%h min %h/%h max %h/%h",
                                  " cnt %0d/%0d empty %b/%b st %0d/%0d"},
                                 want.removed, got.removed, want.min_v, got.min_v,
                                 want.max_v, got.max_v, want.cnt, got.cnt,
                                 want.empty, got.empty, want.status, got.status);
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("tb_interval_heap_double_ended_queue_top: done, errors");
                $finish;
            end
            if (input_done && pending_results.size() == 0) begin
                repeat (100) @(posedge i_clk);
                if (mismatch_count == 0 && pending_results.size() == 0)
                    $display("tb_interval_heap_double_ended_queue_top: done, clean");
                else
                    $display("tb_interval_heap_double_ended_queue_top: done, errors");
                $finish;
            end
        end
    end

endmodule

FILE: filelist.f
hdl/ihdeq_pkg.sv
hdl/interval_heap_double_ended_queue_top.sv
sim/tb_interval_heap_double_ended_queue_top.sv
